// File: rtl/biquad_pkg.sv
// ----------------------------------------------------------------------------
// biquad_pkg
// shared widths, register indexes, reset values and clamp helpers for the
// bit-serial biquad low-pass section
// ----------------------------------------------------------------------------
`default_nettype none

package biquad_pkg;

    // field and datapath widths
    localparam int COEF_W    = 16;
    localparam int COEF_FRAC = 14;
    localparam int STATE_W   = 40;
    localparam int SAMPLE_W  = 10;
    localparam int X_W       = SAMPLE_W + 1;
    localparam int Y_W       = 16;
    localparam int XP_W      = COEF_W + 1 + X_W;
    localparam int YP_W      = COEF_W + 1 + Y_W;
    localparam int SUM_W     = COEF_W + 2;
    localparam int ACC_W     = STATE_W + 2;
    localparam int YSH_W     = ACC_W - COEF_FRAC;
    localparam int CNT_W     = $clog2(Y_W);
    localparam int CFG_IDX_W = 3;

    // centring offset, full scale of the converter
    localparam int X_OFFSET = (2 ** SAMPLE_W) - 1;

    // round half up before the arithmetic shift
    localparam logic [ACC_W-1:0] ROUND_HALF = ACC_W'(2 ** (COEF_FRAC - 1));

    localparam logic [Y_W-1:0] Y_MAX = {1'b0, {(Y_W-1){1'b1}}};
    localparam logic [Y_W-1:0] Y_MIN = {1'b1, {(Y_W-1){1'b0}}};

    // register map
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_B0,
        REG_B1,
        REG_B2,
        REG_A1,
        REG_A2
    } cfg_reg_t;

    localparam logic [COEF_W-1:0] B0_RST = COEF_W'(329);
    localparam logic [COEF_W-1:0] B1_RST = COEF_W'(658);
    localparam logic [COEF_W-1:0] B2_RST = COEF_W'(329);
    localparam logic [COEF_W-1:0] A1_RST = COEF_W'(-25575);
    localparam logic [COEF_W-1:0] A2_RST = COEF_W'(10509);

    // true when a wide sum does not fit the state width
    function automatic logic state_ovf(input logic [ACC_W-1:0] v);
        logic [ACC_W-STATE_W:0] hi;
        begin
            hi = v[ACC_W-1:STATE_W-1];
            state_ovf = !((&hi) || !(|hi));
        end
    endfunction

    // clamp a wide sum to the signed state range
    function automatic logic [STATE_W-1:0] state_clamp(input logic [ACC_W-1:0] v);
        begin
            if (!state_ovf(v))
                state_clamp = v[STATE_W-1:0];
            else if (v[ACC_W-1])
                state_clamp = {1'b1, {(STATE_W-1){1'b0}}};
            else
                state_clamp = {1'b0, {(STATE_W-1){1'b1}}};
        end
    endfunction

endpackage

`default_nettype wire

// File: rtl/biquad_iir_lowpass_top.sv
// ----------------------------------------------------------------------------
// biquad_iir_lowpass_top
// second-order low-pass section, transposed direct form ii, with bit-serial
// shift-and-add multipliers for the feedforward and feedback products
// ----------------------------------------------------------------------------
// flow: a sample beat is taken only while idle, so the next sample waits
//   until the last one is through; it passes through 11 serial steps over the
//   centred sample bits, a rounding step, 16 serial steps over the output
//   bits and a state update, which also waits for a free output slot, and
//   the section then returns to idle, where the next sample beat is taken
// reset: coefficients take their default low-pass values, both delay states
//   clear to zero and no result is pending
`default_nettype none

module biquad_iir_lowpass_top (
    input  wire logic                                   clk,
    input  wire logic                                   rst_n,
    // sample channel
    input  wire logic                                   in_valid,
    output logic                                        in_stall,
    input  wire logic [biquad_pkg::SAMPLE_W-1:0]        adc_sample,
    // result channel
    output logic                                        out_valid,
    input  wire logic                                   out_stall,
    output logic [biquad_pkg::Y_W-1:0]                  filtered,
    output logic                                        saturated,
    // coefficient write port
    input  wire logic                                   cfg_wr_en,
    input  wire logic [biquad_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  wire logic [biquad_pkg::COEF_W-1:0]          cfg_data
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_MULX,
        S_YOUT,
        S_MULY,
        S_UPD
    } state_t;

    state_t state_reg, state_next;

    // coefficients, b0..b2 feed the sample products, a1..a2 the output ones
    logic [biquad_pkg::COEF_W-1:0] coef_b_reg [3];
    logic [biquad_pkg::COEF_W-1:0] coef_b_next [3];
    logic [biquad_pkg::COEF_W-1:0] coef_a_reg [2];
    logic [biquad_pkg::COEF_W-1:0] coef_a_next [2];

    // delay line state
    logic [biquad_pkg::STATE_W-1:0] z1_reg, z1_next;
    logic [biquad_pkg::STATE_W-1:0] z2_reg, z2_next;

    // serial operands and partial products
    logic [biquad_pkg::X_W-1:0]   x_sh_reg, x_sh_next;
    logic [biquad_pkg::Y_W-1:0]   y_sh_reg, y_sh_next;
    logic [biquad_pkg::Y_W-1:0]   y_reg, y_next;
    logic [biquad_pkg::XP_W-1:0]  pb_reg [3];
    logic [biquad_pkg::XP_W-1:0]  pb_next [3];
    logic [biquad_pkg::YP_W-1:0]  pa_reg [2];
    logic [biquad_pkg::YP_W-1:0]  pa_next [2];
    logic [biquad_pkg::YP_W-1:0]  pa_step [2];
    logic [biquad_pkg::XP_W-1:0]  pb_step [3];
    logic [biquad_pkg::CNT_W-1:0] cnt_reg, cnt_next;
    logic                         sat_reg, sat_next;

    // result register
    logic                         out_valid_reg, out_valid_next;
    logic [biquad_pkg::Y_W-1:0]   filtered_reg, filtered_next;
    logic                         saturated_reg, saturated_next;

    // datapath helpers
    logic [biquad_pkg::X_W:0]     x_wide;
    logic                         x_last;
    logic                         y_last;
    logic [biquad_pkg::ACC_W-1:0] y_acc;
    logic [biquad_pkg::YSH_W-1:0] y_shifted;
    logic [biquad_pkg::YSH_W-biquad_pkg::Y_W:0] y_hi;
    logic                         y_ovf;
    logic [biquad_pkg::Y_W-1:0]   y_val;
    logic [biquad_pkg::ACC_W-1:0] n1_acc;
    logic [biquad_pkg::ACC_W-1:0] n2_acc;
    logic                         out_free;
    logic                         in_take;

    assign in_stall  = (state_reg != S_IDLE);
    assign in_take   = in_valid && !in_stall;
    assign out_valid = out_valid_reg;
    assign filtered  = filtered_reg;
    assign saturated = saturated_reg;

    // output slot is free when empty or being drained this cycle
    assign out_free = !out_valid_reg || !out_stall;

    // centre the sample: x = 2*sample - full scale, half-lsb units
    assign x_wide = {1'b0, adc_sample, 1'b0} - (biquad_pkg::X_W + 1)'(biquad_pkg::X_OFFSET);

    assign x_last = (cnt_reg == biquad_pkg::CNT_W'(biquad_pkg::X_W - 1));
    assign y_last = (cnt_reg == biquad_pkg::CNT_W'(biquad_pkg::Y_W - 1));

    // one shift-and-add step per lane; the sign bit of the serial operand
    // carries negative weight, so the last step subtracts the coefficient
    always_comb
    begin
        logic [biquad_pkg::SUM_W-1:0] cext;
        logic [biquad_pkg::SUM_W-1:0] addend;
        logic [biquad_pkg::SUM_W-1:0] hext;
        logic [biquad_pkg::SUM_W-1:0] sum;
        for (int i = 0; i < 3; i++)
        begin
            cext   = {{2{coef_b_reg[i][biquad_pkg::COEF_W-1]}}, coef_b_reg[i]};
            hext   = {pb_reg[i][biquad_pkg::XP_W-1], pb_reg[i][biquad_pkg::XP_W-1:biquad_pkg::X_W]};
            addend = !x_sh_reg[0] ? '0 : (x_last ? (-cext) : cext);
            sum    = hext + addend;
            pb_step[i] = {sum, pb_reg[i][biquad_pkg::X_W-1:1]};
        end
        for (int i = 0; i < 2; i++)
        begin
            cext   = {{2{coef_a_reg[i][biquad_pkg::COEF_W-1]}}, coef_a_reg[i]};
            hext   = {pa_reg[i][biquad_pkg::YP_W-1], pa_reg[i][biquad_pkg::YP_W-1:biquad_pkg::Y_W]};
            addend = !y_sh_reg[0] ? '0 : (y_last ? (-cext) : cext);
            sum    = hext + addend;
            pa_step[i] = {sum, pa_reg[i][biquad_pkg::Y_W-1:1]};
        end
    end

    // output: b0*x + z1, round half up, shift, clamp to 16 bits
    assign y_acc = {{(biquad_pkg::ACC_W - biquad_pkg::X_W - biquad_pkg::COEF_W)
                      {pb_reg[0][biquad_pkg::X_W+biquad_pkg::COEF_W-1]}},
                    pb_reg[0][biquad_pkg::X_W+biquad_pkg::COEF_W-1:0]}
                 + {{(biquad_pkg::ACC_W - biquad_pkg::STATE_W){z1_reg[biquad_pkg::STATE_W-1]}},
                    z1_reg}
                 + biquad_pkg::ROUND_HALF;
    assign y_shifted = y_acc[biquad_pkg::ACC_W-1:biquad_pkg::COEF_FRAC];
    assign y_hi      = y_shifted[biquad_pkg::YSH_W-1:biquad_pkg::Y_W-1];
    assign y_ovf     = !((&y_hi) || !(|y_hi));
    assign y_val     = !y_ovf ? y_shifted[biquad_pkg::Y_W-1:0]
                     : (y_shifted[biquad_pkg::YSH_W-1] ? biquad_pkg::Y_MIN : biquad_pkg::Y_MAX);

    // new state: z1' = b1*x + z2 - a1*y, z2' = b2*x - a2*y
    assign n1_acc = {{(biquad_pkg::ACC_W - biquad_pkg::X_W - biquad_pkg::COEF_W)
                       {pb_reg[1][biquad_pkg::X_W+biquad_pkg::COEF_W-1]}},
                     pb_reg[1][biquad_pkg::X_W+biquad_pkg::COEF_W-1:0]}
                  + {{(biquad_pkg::ACC_W - biquad_pkg::STATE_W){z2_reg[biquad_pkg::STATE_W-1]}},
                     z2_reg}
                  - {{(biquad_pkg::ACC_W - biquad_pkg::Y_W - biquad_pkg::COEF_W)
                       {pa_reg[0][biquad_pkg::Y_W+biquad_pkg::COEF_W-1]}},
                     pa_reg[0][biquad_pkg::Y_W+biquad_pkg::COEF_W-1:0]};
    assign n2_acc = {{(biquad_pkg::ACC_W - biquad_pkg::X_W - biquad_pkg::COEF_W)
                       {pb_reg[2][biquad_pkg::X_W+biquad_pkg::COEF_W-1]}},
                     pb_reg[2][biquad_pkg::X_W+biquad_pkg::COEF_W-1:0]}
                  - {{(biquad_pkg::ACC_W - biquad_pkg::Y_W - biquad_pkg::COEF_W)
                       {pa_reg[1][biquad_pkg::Y_W+biquad_pkg::COEF_W-1]}},
                     pa_reg[1][biquad_pkg::Y_W+biquad_pkg::COEF_W-1:0]};

    // next-state logic
    always_comb
    begin
        state_next     = state_reg;
        coef_b_next    = coef_b_reg;
        coef_a_next    = coef_a_reg;
        z1_next        = z1_reg;
        z2_next        = z2_reg;
        x_sh_next      = x_sh_reg;
        y_sh_next      = y_sh_reg;
        y_next         = y_reg;
        pb_next        = pb_reg;
        pa_next        = pa_reg;
        cnt_next       = cnt_reg;
        sat_next       = sat_reg;
        out_valid_next = out_valid_reg;
        filtered_next  = filtered_reg;
        saturated_next = saturated_reg;

        // result beat drained
        if (out_valid_reg && !out_stall)
            out_valid_next = 1'b0;

        // coefficient writes, only the listed indexes land
        if (cfg_wr_en)
        begin
            case (cfg_index)
                biquad_pkg::REG_B0: coef_b_next[0] = cfg_data;
                biquad_pkg::REG_B1: coef_b_next[1] = cfg_data;
                biquad_pkg::REG_B2: coef_b_next[2] = cfg_data;
                biquad_pkg::REG_A1: coef_a_next[0] = cfg_data;
                biquad_pkg::REG_A2: coef_a_next[1] = cfg_data;
                default: ;
            endcase
        end

        case (state_reg)
            S_IDLE:
            begin
                if (in_take)
                begin
                    x_sh_next  = x_wide[biquad_pkg::X_W-1:0];
                    pb_next    = '{default: '0};
                    cnt_next   = '0;
                    state_next = S_MULX;
                end
            end
            S_MULX:
            begin
                pb_next   = pb_step;
                x_sh_next = {1'b0, x_sh_reg[biquad_pkg::X_W-1:1]};
                cnt_next  = cnt_reg + 1'b1;
                if (x_last)
                    state_next = S_YOUT;
            end
            S_YOUT:
            begin
                y_next     = y_val;
                y_sh_next  = y_val;
                sat_next   = y_ovf;
                pa_next    = '{default: '0};
                cnt_next   = '0;
                state_next = S_MULY;
            end
            S_MULY:
            begin
                pa_next   = pa_step;
                y_sh_next = {1'b0, y_sh_reg[biquad_pkg::Y_W-1:1]};
                cnt_next  = cnt_reg + 1'b1;
                if (y_last)
                    state_next = S_UPD;
            end
            S_UPD:
            begin
                // commit the state together with the result beat
                if (out_free)
                begin
                    z1_next        = biquad_pkg::state_clamp(n1_acc);
                    z2_next        = biquad_pkg::state_clamp(n2_acc);
                    out_valid_next = 1'b1;
                    filtered_next  = y_reg;
                    saturated_next = sat_reg || biquad_pkg::state_ovf(n1_acc)
                                   || biquad_pkg::state_ovf(n2_acc);
                    state_next     = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    // control, coefficients, filter state and result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            coef_b_reg[0] <= biquad_pkg::B0_RST;
            coef_b_reg[1] <= biquad_pkg::B1_RST;
            coef_b_reg[2] <= biquad_pkg::B2_RST;
            coef_a_reg[0] <= biquad_pkg::A1_RST;
            coef_a_reg[1] <= biquad_pkg::A2_RST;
            z1_reg        <= '0;
            z2_reg        <= '0;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
            filtered_reg  <= '0;
            saturated_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            coef_b_reg    <= coef_b_next;
            coef_a_reg    <= coef_a_next;
            z1_reg        <= z1_next;
            z2_reg        <= z2_next;
            cnt_reg       <= cnt_next;
            out_valid_reg <= out_valid_next;
            filtered_reg  <= filtered_next;
            saturated_reg <= saturated_next;
        end
    end

    // serial datapath, no reset needed
    always_ff @(posedge clk)
    begin
        x_sh_reg <= x_sh_next;
        y_sh_reg <= y_sh_next;
        y_reg    <= y_next;
        pb_reg   <= pb_next;
        pa_reg   <= pa_next;
        sat_reg  <= sat_next;
    end

    // a taken sample always starts the sample-bit pass
    a_take_starts: assert property (@(posedge clk) disable iff (!rst_n)
        in_take |=> (state_reg == S_MULX) && (cnt_reg == '0))
        else $error("sample beat did not start the multiply pass");

    // the delay state moves only on the update cycle
    a_state_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != S_UPD) |=> ($stable(z1_reg) && $stable(z2_reg)))
        else $error("delay state changed outside the update cycle");

    // a result beat is loaded only from the update cycle
    a_result_src: assert property (@(posedge clk) disable iff (!rst_n)
        (!out_valid_reg || !out_stall) && (state_reg != S_UPD) |=> !out_valid_reg)
        else $error("result beat appeared without an update");

    // sample pass never runs past the sample width
    a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_MULX) |-> (cnt_reg <= biquad_pkg::CNT_W'(biquad_pkg::X_W - 1)))
        else $error("sample pass counter out of range");

endmodule

`default_nettype wire
